FILE: src/cs_pkg.sv
// shared widths, codes and types for the contrast stretch block
package cs_pkg;

  localparam int GrayBits  = 16;
  localparam int PixelBits = 16;
  localparam int ProdBits  = 2 * GrayBits;
  localparam int StepBits  = $clog2(GrayBits);
  localparam int ApbBits   = 32;
  localparam int AddrBits  = 3;
  localparam int RegBits   = AddrBits - 2;

  typedef logic [GrayBits-1:0] gray_t;
  typedef logic [ProdBits-1:0] prod_t;
  typedef logic [ApbBits-1:0]  apb_data_t;
  typedef logic [AddrBits-1:0] apb_addr_t;

  localparam logic [RegBits-1:0] RegMaxGray = '0;
  localparam gray_t              GrayReset  = gray_t'(255);

  localparam logic OpMeasure = 1'b0;
  localparam logic OpStretch = 1'b1;

endpackage

FILE: src/cs_ifs.sv
// stream channel interfaces for pixel items and stretched results
interface cs_in_if;
  import cs_pkg::*;
  logic  valid;
  logic  ready;
  logic  op;
  gray_t pixel;
  logic  frame_start;
  modport source (output valid, op, pixel, frame_start, input ready);
  modport sink (input valid, op, pixel, frame_start, output ready);
endinterface

interface cs_out_if;
  import cs_pkg::*;
  logic  valid;
  logic  ready;
  gray_t stretched;
  logic  flat;
  modport source (output valid, stretched, flat, input ready);
  modport sink (input valid, stretched, flat, output ready);
endinterface

FILE: src/contrast_stretch.sv
// min-max contrast stretch: min/max tracking, serial multiply and divide
// measure items: accepted one per cycle while no stretch item is in progress, no result
// stretch items: result goes through the serial multiplier, the serial divider
//   and then the output register; with a flat range only the output register
// next item: taken only after the result is loaded into the output register
// reset: synchronous, min 255, max 0, max_gray 255, output register empty
module contrast_stretch (
  input  logic              clk,
  input  logic              rst,
  cs_in_if.sink             item,
  cs_out_if.source          result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  cs_pkg::apb_addr_t paddr,
  input  cs_pkg::apb_data_t pwdata,
  output cs_pkg::apb_data_t prdata,
  output logic              pready
);
  import cs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_DIV  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  gray_t  max_gray;
  gray_t  min_seen;
  gray_t  max_seen;
  gray_t  rng;
  logic   res_flat;
  logic   out_valid;
  gray_t  out_stretched;
  logic   out_flat;

  logic   accept;
  gray_t  pix;
  gray_t  base_min;
  gray_t  base_max;
  logic   flat_now;
  gray_t  pix_clamp;
  gray_t  offset;
  logic   mul_start;
  logic   mul_done;
  prod_t  prod;
  logic   div_start;
  logic   div_done;
  gray_t  quo;
  logic   out_load;

  cs_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .max_gray (max_gray)
  );

  assign accept   = item.valid && item.ready;
  assign pix      = gray_t'(item.pixel[PixelBits-1:0]);
  assign base_min = item.frame_start ? max_gray : min_seen;
  assign base_max = item.frame_start ? '0 : max_seen;
  assign flat_now = (max_seen <= min_seen);

  always_comb begin
    pix_clamp = pix;
    if (pix < min_seen) begin
      pix_clamp = min_seen;
    end
    if (pix > max_seen) begin
      pix_clamp = max_seen;
    end
  end

  assign offset    = pix_clamp - min_seen;
  assign mul_start = accept && (item.op == OpStretch) && !flat_now;
  assign div_start = (state == S_MUL) && mul_done;
  assign out_load  = (state == S_OUT) && (!out_valid || result.ready);

  cs_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (offset),
    .b     (max_gray),
    .done  (mul_done),
    .prod  (prod)
  );

  cs_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (prod),
    .den   (rng),
    .done  (div_done),
    .quo   (quo)
  );

  assign item.ready       = (state == S_IDLE);
  assign result.valid     = out_valid;
  assign result.stretched = out_stretched;
  assign result.flat      = out_flat;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && item.op == OpStretch) begin
          state_next = flat_now ? S_OUT : S_MUL;
        end
      end
      S_MUL: begin
        if (mul_done) begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      min_seen  <= GrayReset;
      max_seen  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && item.op == OpMeasure) begin
        min_seen <= (pix < base_min) ? pix : base_min;
        max_seen <= (pix > base_max) ? pix : base_max;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && item.op == OpStretch) begin
      rng      <= max_seen - min_seen;
      res_flat <= flat_now;
    end
    if (out_load) begin
      out_stretched <= res_flat ? '0 : quo;
      out_flat      <= res_flat;
    end
  end

endmodule

FILE: src/cs_cfg.sv
// apb register file holding max_gray
module cs_cfg (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  cs_pkg::apb_addr_t paddr,
  input  cs_pkg::apb_data_t pwdata,
  output cs_pkg::apb_data_t prdata,
  output logic              pready,
  output cs_pkg::gray_t     max_gray
);
  import cs_pkg::*;

  logic hit;

  assign hit    = (paddr[AddrBits-1:2] == RegMaxGray);
  assign pready = 1'b1;
  assign prdata = hit ? apb_data_t'(max_gray) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_gray <= GrayReset;
    end else if (psel && penable && pwrite && pready && hit) begin
      max_gray <= pwdata[GrayBits-1:0];
    end
  end

endmodule

FILE: src/cs_mul.sv
// bit-serial shift-add multiplier, one multiplier bit per cycle
module cs_mul (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  cs_pkg::gray_t a,
  input  cs_pkg::gray_t b,
  output logic          done,
  output cs_pkg::prod_t prod
);
  import cs_pkg::*;

  logic                busy;
  logic [StepBits-1:0] cnt;
  gray_t               mcand;
  logic [GrayBits:0]   sum;

  assign sum = prod[0] ? ({1'b0, prod[ProdBits-1:GrayBits]} + {1'b0, mcand})
                       : {1'b0, prod[ProdBits-1:GrayBits]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= StepBits'(GrayBits - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod  <= prod_t'(a);
      mcand <= b;
    end else if (busy) begin
      prod <= {sum, prod[GrayBits-1:1]};
    end
  end

endmodule

FILE: src/cs_div.sv
// restoring divider, one quotient bit per cycle, quotient known to fit gray_t
module cs_div (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  cs_pkg::prod_t num,
  input  cs_pkg::gray_t den,
  output logic          done,
  output cs_pkg::gray_t quo
);
  import cs_pkg::*;

  logic                busy;
  logic [StepBits-1:0] cnt;
  gray_t               rem;
  gray_t               dsor;
  logic [GrayBits:0]   trial;
  logic [GrayBits:0]   diff;
  logic                ge;

  assign trial = {rem, quo[GrayBits-1]};
  assign diff  = trial - {1'b0, dsor};
  assign ge    = (trial >= {1'b0, dsor});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= StepBits'(GrayBits - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= num[ProdBits-1:GrayBits];
      quo  <= num[GrayBits-1:0];
      dsor <= den;
    end else if (busy) begin
      rem <= ge ? diff[GrayBits-1:0] : trial[GrayBits-1:0];
      quo <= {quo[GrayBits-2:0], ge};
    end
  end

endmodule

FILE: tb/tb_top.sv
// self-checking testbench for contrast_stretch: random pixel frames, stalls and max_gray settings
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import cs_pkg::*;

  localparam int        SettleCycles   = 40;
  localparam int        WatchdogCycles = 1000;
  localparam int        PhaseItems     = 80;
  localparam apb_addr_t MaxGrayAddr    = apb_addr_t'({RegMaxGray, 2'b00});
  localparam gray_t     PixMask        = gray_t'((32'd1 << PixelBits) - 1);

  typedef struct {
    logic  op;
    gray_t pixel;
    logic  frame_start;
    bit    drain;
  } pixel_item_t;

  typedef struct {
    gray_t stretched;
    logic  flat;
  } level_t;

  logic      clk;
  logic      rst;
  logic      psel;
  logic      penable;
  logic      pwrite;
  apb_addr_t paddr;
  apb_data_t pwdata;
  apb_data_t prdata;
  logic      pready;

  cs_in_if  pix_ch ();
  cs_out_if res_ch ();

  contrast_stretch DUT (
    .clk     (clk),
    .rst     (rst),
    .item    (pix_ch),
    .result  (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  pixel_item_t pixel_queue[$];
  level_t      levels_due[$];
  pixel_item_t on_wire;

  gray_t gray_level;
  gray_t low_seen;
  gray_t high_seen;

  int errors;
  int measure_count;
  int stretch_count;
  int flat_count;
  int setting_count;
  int random_items;
  int feed_gap_odds;
  int drain_stall_odds;
  int feed_gap_left;
  int drain_stall_left;
  int quiet_cycles;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // prediction of one accepted pixel item
  task automatic fold_or_stretch(input pixel_item_t it);
    gray_t  p;
    prod_t  scaled;
    level_t lv;
    p = it.pixel & PixMask;
    if (it.op == OpMeasure) begin
      measure_count++;
      if (it.frame_start) begin
        low_seen  = gray_level;
        high_seen = '0;
      end
      if (p < low_seen) low_seen = p;
      if (p > high_seen) high_seen = p;
    end else begin
      stretch_count++;
      if (high_seen <= low_seen) begin
        lv.stretched = '0;
        lv.flat      = 1'b1;
      end else begin
        if (p < low_seen) p = low_seen;
        if (p > high_seen) p = high_seen;
        scaled       = prod_t'(p - low_seen) * prod_t'(gray_level);
        scaled       = scaled / prod_t'(high_seen - low_seen);
        lv.stretched = gray_t'(scaled);
        lv.flat      = 1'b0;
      end
      levels_due.push_back(lv);
    end
  endtask

  // pixel driver
  always @(posedge clk) begin
    if (rst) begin
      pix_ch.valid <= 1'b0;
      feed_gap_left = 0;
    end else begin
      if (pix_ch.valid && pix_ch.ready) fold_or_stretch(on_wire);
      if (!pix_ch.valid || pix_ch.ready) begin
        if (feed_gap_left > 0) begin
          feed_gap_left--;
          pix_ch.valid <= 1'b0;
        end else if (pixel_queue.size() == 0 ||
                     (pixel_queue[0].drain && levels_due.size() != 0)) begin
          pix_ch.valid <= 1'b0;
        end else if ($urandom_range(99, 0) < feed_gap_odds) begin
          feed_gap_left = $urandom_range(2, 0);
          pix_ch.valid <= 1'b0;
        end else begin
          on_wire = pixel_queue.pop_front();
          pix_ch.valid       <= 1'b1;
          pix_ch.op          <= on_wire.op;
          pix_ch.pixel       <= on_wire.pixel;
          pix_ch.frame_start <= on_wire.frame_start;
        end
      end
    end
  end

  // result monitor and stall generator
  always @(posedge clk) begin
    level_t want;
    if (rst) begin
      res_ch.ready <= 1'b0;
      drain_stall_left = 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (levels_due.size() == 0) begin
          errors++;
          $display("%0t: result with none expected: stretched=%0d flat=%0b",
                   $time, res_ch.stretched, res_ch.flat);
        end else begin
          want = levels_due.pop_front();
          if (res_ch.flat === 1'b1) flat_count++;
          if (res_ch.stretched !== want.stretched) begin
            errors++;
            $display("%0t: stretched mismatch: expected %0d, got %0d",
                     $time, want.stretched, res_ch.stretched);
          end
          if (res_ch.flat !== want.flat) begin
            errors++;
            $display("%0t: flat mismatch: expected %0b, got %0b",
                     $time, want.flat, res_ch.flat);
          end
        end
      end
      if (drain_stall_left > 0) begin
        drain_stall_left--;
        res_ch.ready <= 1'b0;
      end else if ($urandom_range(99, 0) < drain_stall_odds) begin
        drain_stall_left = $urandom_range(2, 0);
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogCycles) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic add_item(input logic op, input int pixel, input logic fs, input bit drain = 0);
    pixel_item_t it;
    it.op          = op;
    it.pixel       = gray_t'(pixel);
    it.frame_start = fs;
    it.drain       = drain;
    pixel_queue.push_back(it);
  endtask

  task automatic apb_access(input logic wr, input gray_t value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= MaxGrayAddr;
    pwdata  <= apb_data_t'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (!wr && prdata[GrayBits-1:0] !== value) begin
      errors++;
      $display("%0t: max_gray readback mismatch: expected %0d, got %0d",
               $time, value, prdata[GrayBits-1:0]);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_max_gray(input gray_t value);
    apb_access(1'b1, value);
    gray_level = value;
    setting_count++;
    apb_access(1'b0, value);
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pixel_queue.size() != 0 || pix_ch.valid || levels_due.size() != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // one measured frame followed by stretch items, or a burst of noise
  task automatic queue_frame();
    int lo;
    int hi;
    int n;
    if ($urandom_range(99, 0) < 12) begin
      n = $urandom_range(6, 1);
      repeat (n) add_item(1'($urandom_range(1, 0)), $urandom_range(65535, 0),
                          1'($urandom_range(1, 0)));
      random_items += n;
      return;
    end
    case ($urandom_range(4, 0))
      0: begin
        lo = $urandom_range(65535, 0);
        hi = lo;
      end
      1: begin
        lo = $urandom_range(255, 0);
        hi = lo + $urandom_range(255, 1);
      end
      2: begin
        lo = 0;
        hi = 65535;
      end
      default: begin
        lo = $urandom_range(65535, 0);
        hi = $urandom_range(65535, lo);
      end
    endcase
    add_item(OpMeasure, lo, $urandom_range(99, 0) < 90);
    n = $urandom_range(8, 0);
    repeat (n) add_item(OpMeasure, $urandom_range(hi, lo), 1'b0);
    add_item(OpMeasure, hi, 1'b0);
    random_items += n + 2;
    n = $urandom_range(10, 1);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99, 0) < 80)
        add_item(OpStretch, $urandom_range(hi, lo), 1'($urandom_range(1, 0)),
                 i == 0 && $urandom_range(29, 0) == 0);
      else
        add_item(OpStretch, $urandom_range(65535, 0), 1'($urandom_range(1, 0)));
    end
    random_items += n;
  endtask

  initial begin
    gray_t settings[8];
    rst              = 1'b1;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    pix_ch.valid       = 1'b0;
    pix_ch.op          = OpMeasure;
    pix_ch.pixel       = '0;
    pix_ch.frame_start = 1'b0;
    res_ch.ready     = 1'b0;
    errors           = 0;
    measure_count    = 0;
    stretch_count    = 0;
    flat_count       = 0;
    setting_count    = 0;
    random_items     = 0;
    feed_gap_odds    = 20;
    drain_stall_odds = 20;
    gray_level       = GrayReset;
    low_seen         = GrayReset;
    high_seen        = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: reset range, flat and inverted ranges, clamping, extremes
    apb_access(1'b0, GrayReset);
    add_item(OpStretch, 100, 1'b1);
    add_item(OpStretch, 0, 1'b0);
    add_item(OpMeasure, 0, 1'b0);
    add_item(OpStretch, 65535, 1'b0);
    add_item(OpMeasure, 65535, 1'b0);
    add_item(OpStretch, 0, 1'b0);
    add_item(OpStretch, 65535, 1'b0);
    add_item(OpStretch, 'h8000, 1'b0);
    add_item(OpMeasure, 200, 1'b1);
    add_item(OpStretch, 200, 1'b0);
    add_item(OpMeasure, 50, 1'b0);
    add_item(OpStretch, 10, 1'b0);
    add_item(OpStretch, 300, 1'b0);
    add_item(OpStretch, 125, 1'b0, 1'b1);
    add_item(OpMeasure, 'h5555, 1'b1);
    add_item(OpMeasure, 'hAAAA, 1'b0);
    add_item(OpStretch, 'h1234, 1'b0);
    add_item(OpStretch, 'hAAAA, 1'b0);
    add_item(OpStretch, 'hFFFF, 1'b1);
    wait_idle();

    settings = '{16'hFFFF, 16'd1, 16'd0, gray_t'($urandom_range(65534, 2)),
                 gray_t'($urandom_range(255, 1)), 16'd4095,
                 gray_t'($urandom_range(65535, 0)), GrayReset};
    foreach (settings[k]) begin
      set_max_gray(settings[k]);
      if (k == 7) begin
        feed_gap_odds    = 0;
        drain_stall_odds = 0;
      end else begin
        feed_gap_odds    = $urandom_range(40, 0);
        drain_stall_odds = $urandom_range(40, 0);
      end
      while (random_items < (k + 1) * PhaseItems) queue_frame();
      wait_idle();
    end

    $display("covered %0d measure and %0d stretch transfers, %0d of them flat",
             measure_count, stretch_count, flat_count);
    $display("max_gray written %0d times, extremes 0, 1 and 65535 included", setting_count);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
